// File: sv/tcw_pkg.sv
package tcw_pkg;

  // Fixed widths of the word fields
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  // Widest cell address over the supported screen sizes (128 x 32)
  localparam int ADDR_W = 12;

  // Character codes
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [7:0]        TEXT_COLOR_RESET = 8'h0F;
  localparam logic [CELL_W-1:0] CELL_RESET       = 16'h0F20;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    req_type_t  req_type;
    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [6:0] cell_column;
    logic [4:0] cell_row;
  } req_item_t;

  // One write port and one read port of the screen memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ctrl_stat_t;

  // Build a cell: attribute in the high byte, newline shown as a space
  function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] ch,
                                                  input logic [7:0] attr);
    logic [7:0] c;
    c = (ch == CH_NEWLINE) ? CH_SPACE : ch;
    return {attr, c};
  endfunction

endpackage

// File: sv/tcw_if.sv
interface tcw_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;
  logic [7:0] cell_color;
  logic [6:0] cell_column;
  logic [4:0] cell_row;

  modport source (output valid, req_type, char_code, cell_color, cell_column, cell_row,
                  input ready);
  modport sink (input valid, req_type, char_code, cell_color, cell_column, cell_row,
                output ready);
endinterface

interface tcw_rsp_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_position;
  logic [15:0] cell_data;

  modport source (output valid, cursor_position, cell_data, input ready);
  modport sink (input valid, cursor_position, cell_data, output ready);
endinterface

interface tcw_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_color;

  modport source (output valid, text_color, input ready);
  modport sink (input valid, text_color, output ready);
endinterface

// File: sv/text_console_writer_top.sv
// Text console: an 80x25 (COLUMNS x ROWS) screen of 16-bit cells, character in
// the low byte and attribute in the high byte, held in one dual-port memory.
// Every request word returns one result word with the cursor position after
// the request and, for a read, the cell contents. Put-character, write-cell,
// off-screen read and unused request types complete straight from the idle
// state; a read of a cell on the screen waits in ST_READ for the registered
// memory read. A put-character that moves the cursor past the bottom row
// scrolls the screen by copying every cell through the memory, one cell per
// cycle. After reset the block clears the memory to white-on-black spaces,
// one cell per cycle, and accepts no request until the clear is done;
// text_color writes are taken at any time. A finished result waits in an
// output register plus one skid stage, so the next request is taken while
// the previous result is still pending on the result channel.
module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic         clk,
  input logic         rst,
  tcw_req_if.sink     req,
  tcw_rsp_if.source   rsp,
  tcw_cfg_if.sink     cfg
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [7:0]        text_color;
  logic              accept;
  req_item_t         item;
  mem_req_t          mem;
  ctrl_stat_t        stat;
  logic [CELL_W-1:0] rd_data;
  logic [CELL_W-1:0] done_data;
  logic [POS_W-1:0]  cursor_pos;

  logic              pend_valid;
  logic [CELL_W-1:0] pend_data;
  logic              out_valid;
  logic [POS_W-1:0]  out_pos;
  logic [CELL_W-1:0] out_data;
  logic              move;

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= TEXT_COLOR_RESET;
    end else if (cfg.valid) begin
      text_color <= cfg.text_color;
    end
  end

  // Take a word only when idle and the skid stage is empty
  assign req.ready = stat.idle && !pend_valid;
  assign accept    = req.valid && req.ready;

  assign item.req_type    = req_type_t'(req.req_type);
  assign item.char_code   = req.char_code;
  assign item.cell_color  = req.cell_color;
  assign item.cell_column = req.cell_column;
  assign item.cell_row    = req.cell_row;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .text_color (text_color),
    .rd_data    (rd_data),
    .mem        (mem),
    .stat       (stat),
    .done_data  (done_data),
    .cursor_pos (cursor_pos)
  );

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .mem     (mem),
    .rd_data (rd_data)
  );

  // Advance the skid word into the output register when it is free
  assign move = pend_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (stat.done) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold result payload; cursor is final once the result is complete
  always_ff @(posedge clk) begin
    if (stat.done) begin
      pend_data <= done_data;
    end
    if (move) begin
      out_data <= pend_data;
      out_pos  <= cursor_pos;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.cursor_position = out_pos;
  assign rsp.cell_data       = out_data;

`ifndef ASSERT_OFF
  a_done_skid_free: assert property (@(posedge clk) disable iff (rst)
    !(stat.done && pend_valid))
    else $error("result completed while skid stage was full");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !out_valid) |=> (out_valid && !pend_valid))
    else $error("skid word did not move to empty output register");

  a_mem_port_free: assert property (@(posedge clk) disable iff (rst)
    (stat.done && !stat.idle) |-> !accept)
    else $error("word accepted while a result was completing");
`endif

endmodule

// File: sv/tcw_screen_ram.sv
module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                     clk,
  input  tcw_pkg::mem_req_t        mem,
  output logic [tcw_pkg::CELL_W-1:0] rd_data
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] cells [DEPTH];

  // Write one cell, read one cell with registered data
  always_ff @(posedge clk) begin
    if (mem.we) begin
      cells[mem.waddr[AW-1:0]] <= mem.wdata;
    end
    if (mem.re) begin
      rd_data <= cells[mem.raddr[AW-1:0]];
    end
  end

endmodule

// File: sv/tcw_ctrl.sv
module tcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  tcw_pkg::req_item_t         item,
  input  logic [7:0]                 text_color,
  input  logic [tcw_pkg::CELL_W-1:0] rd_data,
  output tcw_pkg::mem_req_t          mem,
  output tcw_pkg::ctrl_stat_t        stat,
  output logic [tcw_pkg::CELL_W-1:0] done_data,
  output logic [tcw_pkg::POS_W-1:0]  cursor_pos
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
  localparam logic [AW-1:0]     IDX_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0]     IDX_KEEP = AW'(CELLS - COLUMNS);
  localparam logic [6:0]        COL_LAST = 7'(COLUMNS - 1);
  localparam logic [4:0]        ROW_LAST = 5'(ROWS - 1);

  ctrl_state_t state, state_next;
  logic [AW-1:0]     idx, idx_next;
  logic [4:0]        cur_row, row_next;
  logic [6:0]        cur_col, col_next;
  logic              wp_valid, wp_valid_next;
  logic [ADDR_W-1:0] wp_addr, wp_addr_next;
  logic              wp_blank, wp_blank_next;

  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] item_addr;
  logic              in_range;

  assign cur_addr   = ADDR_W'(cur_row) * COLS_A + ADDR_W'(cur_col);
  assign cursor_pos = cur_addr[POS_W-1:0];
  assign item_addr  = ADDR_W'(item.cell_row) * COLS_A + ADDR_W'(item.cell_column);
  assign in_range   = ({1'b0, item.cell_column} < 8'(COLUMNS)) &&
                      ({1'b0, item.cell_row} < 6'(ROWS));

  // State, sweep index, cursor and delayed scroll write
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      idx      <= '0;
      cur_row  <= '0;
      cur_col  <= '0;
      wp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      cur_row  <= row_next;
      cur_col  <= col_next;
      wp_valid <= wp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    wp_addr  <= wp_addr_next;
    wp_blank <= wp_blank_next;
  end

  // Next state, memory accesses and completion
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    row_next      = cur_row;
    col_next      = cur_col;
    wp_valid_next = 1'b0;
    wp_addr_next  = wp_addr;
    wp_blank_next = wp_blank;
    mem           = '0;
    stat          = '0;
    done_data     = '0;

    // Retire the scroll write whose source was read last cycle
    if (wp_valid) begin
      mem.we    = 1'b1;
      mem.waddr = wp_addr;
      mem.wdata = wp_blank ? make_cell(CH_SPACE, text_color) : rd_data;
    end

    unique case (state)
      ST_CLEAR: begin
        mem.we    = 1'b1;
        mem.waddr = ADDR_W'(idx);
        mem.wdata = CELL_RESET;
        idx_next  = idx + 1'b1;
        if (idx == IDX_LAST) begin
          idx_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        stat.idle = 1'b1;
        if (accept) begin
          unique case (item.req_type)
            REQ_PUT: begin
              if (item.char_code == CH_RETURN) begin
                col_next  = '0;
                stat.done = 1'b1;
              end else begin
                mem.we    = 1'b1;
                mem.waddr = cur_addr;
                mem.wdata = make_cell(item.char_code, text_color);
                if (cur_col == COL_LAST || item.char_code == CH_NEWLINE) begin
                  col_next = '0;
                  if (cur_row == ROW_LAST) begin
                    idx_next   = '0;
                    state_next = ST_SCROLL;
                  end else begin
                    row_next  = cur_row + 1'b1;
                    stat.done = 1'b1;
                  end
                end else begin
                  col_next  = cur_col + 1'b1;
                  stat.done = 1'b1;
                end
              end
            end
            REQ_READ: begin
              if (in_range) begin
                mem.re     = 1'b1;
                mem.raddr  = item_addr;
                state_next = ST_READ;
              end else begin
                stat.done = 1'b1;
              end
            end
            REQ_WRITE: begin
              if (in_range) begin
                mem.we    = 1'b1;
                mem.waddr = item_addr;
                mem.wdata = make_cell(item.char_code, item.cell_color);
              end
              stat.done = 1'b1;
            end
            REQ_NONE: begin
              stat.done = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        stat.done  = 1'b1;
        done_data  = rd_data;
        state_next = ST_IDLE;
      end
      ST_SCROLL: begin
        // Read the cell one row below and write it in the next cycle; the bottom row is written blank
        wp_valid_next = 1'b1;
        wp_addr_next  = ADDR_W'(idx);
        if (idx < IDX_KEEP) begin
          mem.re        = 1'b1;
          mem.raddr     = ADDR_W'(idx) + COLS_A;
          wp_blank_next = 1'b0;
        end else begin
          wp_blank_next = 1'b1;
        end
        idx_next = idx + 1'b1;
        if (idx == IDX_LAST) begin
          idx_next   = '0;
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        stat.done  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_wp_no_accept: assert property (@(posedge clk) disable iff (rst)
    !(wp_valid && accept))
    else $error("scroll write overlaps an accepted word");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_IDLE)
    else $error("read did not complete in one cycle");

  a_scroll_flush: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCROLL && idx == IDX_LAST) |=> (state == ST_FLUSH && wp_valid))
    else $error("scroll ended without its last write");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    accept |-> ({1'b0, cur_col} < 8'(COLUMNS) && {1'b0, cur_row} < 6'(ROWS)))
    else $error("cursor out of screen");
`endif

endmodule
